/* src/assert_macros.svh */
// assertion macros used by the checker file
// depends on nothing; included by kcf_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define KCF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kcf assertion failed");

// clocked assertion that also checks during reset
`define KCF_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("kcf reset assertion failed");

`endif

/* src/kcf_pkg.sv */
// types, codes and constants of the keyed circular fifo
// depends on nothing; used by every module of the block
package kcf_pkg;

  localparam int KCF_DEPTH        = 16;
  localparam int KCF_PAYLOAD_BITS = 32;
  localparam int MAX_RESULTS      = 16;
  localparam int OP_W             = 3;
  localparam int KEY_W            = 32;
  localparam int PAY_W            = 32;
  localparam int FILL_W           = 5;
  localparam int QUEUE_PTR_W      = 1;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_FIND,
    CMD_DELETE,
    CMD_DUMP,
    CMD_CLEAR,
    CMD_ILLEGAL
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_SHIFT,
    ST_DUMP,
    ST_REPLY
  } back_state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic signed [KEY_W-1:0] record_key;
    logic [PAY_W-1:0]        record_payload;
    logic [FILL_W-1:0]       fill_count;
    logic                    is_full;
    logic                    is_empty;
    logic                    last;
  } out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } cmd_t;

endpackage

/* src/keyed_circular_fifo_core.sv */
// top level of the keyed circular fifo: front stage, command queue, engine
// depends on kcf_pkg, kcf_front, kcf_cmd_queue, kcf_back
//
//  channel   ports                          payload
//  input     in_valid / in_ready            in_data  (kcf_pkg::in_t)
//  result    out_valid / out_ready          out_data (kcf_pkg::out_t)
//
// push, pop, clear and unused codes: one result each
// find: searches from the head and returns the first matching record, or fails on a miss
// delete: on a match, each later record moves one slot toward the head; fails on a miss
// dump: one record per cycle while the result channel is not stalled, through the single read port
// the engine runs one item at a time; up to three more items wait in front of it
// reset is synchronous active low and clears pointers and count, not the memory
module keyed_circular_fifo_core #(
  parameter int DEPTH        = kcf_pkg::KCF_DEPTH,
  parameter int PAYLOAD_BITS = kcf_pkg::KCF_PAYLOAD_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kcf_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kcf_pkg::out_t  out_data
);

  logic           f_valid;
  logic           f_ready;
  kcf_pkg::cmd_t  f_cmd;
  logic           q_valid;
  logic           q_ready;
  kcf_pkg::cmd_t  q_cmd;

  kcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  kcf_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  kcf_back #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/kcf_front.sv */
// front stage: takes input transfers and decodes the operation code
// depends on kcf_pkg
module kcf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kcf_pkg::in_t   in_data,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output kcf_pkg::cmd_t  cmd
);

  logic                  f_valid_r;
  logic                  f_valid_nxt;
  kcf_pkg::cmd_t         f_cmd_r;
  kcf_pkg::cmd_kind_t    kind;

  always_comb begin
    case (in_data.operation)
      kcf_pkg::OP_PUSH:   kind = kcf_pkg::CMD_PUSH;
      kcf_pkg::OP_POP:    kind = kcf_pkg::CMD_POP;
      kcf_pkg::OP_FIND:   kind = kcf_pkg::CMD_FIND;
      kcf_pkg::OP_DELETE: kind = kcf_pkg::CMD_DELETE;
      kcf_pkg::OP_DUMP:   kind = kcf_pkg::CMD_DUMP;
      kcf_pkg::OP_CLEAR:  kind = kcf_pkg::CMD_CLEAR;
      default:            kind = kcf_pkg::CMD_ILLEGAL;
    endcase
  end

  assign in_ready  = !f_valid_r || cmd_ready;
  assign cmd_valid = f_valid_r;
  assign cmd       = f_cmd_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_valid && in_ready) begin
      f_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd_r.kind    <= kind;
      f_cmd_r.key     <= in_data.key;
      f_cmd_r.payload <= in_data.payload;
    end
  end

endmodule

/* src/kcf_cmd_queue.sv */
// two-entry command queue between the front stage and the engine
// depends on kcf_pkg
module kcf_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  kcf_pkg::cmd_t  wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output kcf_pkg::cmd_t  rd_cmd
);

  localparam int QD = 2 ** kcf_pkg::QUEUE_PTR_W;
  localparam int QC = kcf_pkg::QUEUE_PTR_W + 1;

  kcf_pkg::cmd_t                      slot_r [QD];
  logic [kcf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r;
  logic [kcf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_nxt;
  logic [kcf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r;
  logic [kcf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_nxt;
  logic [QC-1:0]                      cnt_r;
  logic [QC-1:0]                      cnt_nxt;
  logic                               do_wr;
  logic                               do_rd;

  assign wr_ready = (cnt_r != QC'(QD));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* src/kcf_back.sv */
// engine: record memory, ring pointers, search, compaction and dump walk,
// result register; depends on kcf_pkg
module kcf_back #(
  parameter int DEPTH        = kcf_pkg::KCF_DEPTH,
  parameter int PAYLOAD_BITS = kcf_pkg::KCF_PAYLOAD_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  kcf_pkg::cmd_t  cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output kcf_pkg::out_t  out_data
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int SW       = (PAYLOAD_BITS < kcf_pkg::PAY_W) ? PAYLOAD_BITS : kcf_pkg::PAY_W;
  localparam int DUMP_CAP = (DEPTH < kcf_pkg::MAX_RESULTS) ? DEPTH : kcf_pkg::MAX_RESULTS;
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] DUMP_LIM  = CW'(DUMP_CAP);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  logic [kcf_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [SW-1:0]             pay_mem [DEPTH];

  kcf_pkg::back_state_t      state_r, state_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [AW-1:0]             tail_r, tail_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [kcf_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      del_r, del_nxt;
  logic [AW-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]             rd_off_r, rd_off_nxt;
  logic [AW-1:0]             cmp_addr_r, cmp_addr_nxt;
  logic [AW-1:0]             wr_addr_r, wr_addr_nxt;
  logic                      rv_r, rv_nxt;
  logic [kcf_pkg::KEY_W-1:0] rd_key_r;
  logic [SW-1:0]             rd_pay_r;
  logic                      rep_status_r, rep_status_nxt;
  logic [kcf_pkg::KEY_W-1:0] rep_key_r, rep_key_nxt;
  logic [SW-1:0]             rep_pay_r, rep_pay_nxt;
  logic                      out_valid_r, out_valid_nxt;
  kcf_pkg::out_t             out_data_r;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [kcf_pkg::KEY_W-1:0] mem_wkey;
  logic [SW-1:0]             mem_wpay;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic                      emit;
  logic                      emit_status;
  logic [kcf_pkg::KEY_W-1:0] emit_key;
  logic [SW-1:0]             emit_pay;
  logic                      emit_last;

  logic                      slot_free;
  logic                      match_now;
  logic                      more_rd;
  logic [CW-1:0]             dump_n;
  logic                      more_dump;
  logic                      dump_emit;
  logic                      dump_last;

  assign slot_free = !out_valid_r || out_ready;
  assign match_now = rv_r && (rd_key_r == key_r);
  assign more_rd   = (rd_off_r < count_r);
  assign dump_n    = (count_r > DUMP_LIM) ? DUMP_LIM : count_r;
  assign more_dump = (rd_off_r < dump_n);
  assign dump_emit = (state_r == kcf_pkg::ST_DUMP) && rv_r && slot_free;
  assign dump_last = (rd_off_r == dump_n);
  assign cmd_ready = (state_r == kcf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kcf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            kcf_pkg::CMD_POP: begin
              state_nxt = (count_r == '0) ? kcf_pkg::ST_REPLY : kcf_pkg::ST_POP;
            end
            kcf_pkg::CMD_FIND, kcf_pkg::CMD_DELETE: begin
              state_nxt = (count_r == '0) ? kcf_pkg::ST_REPLY : kcf_pkg::ST_SEARCH;
            end
            kcf_pkg::CMD_DUMP: begin
              state_nxt = (count_r == '0) ? kcf_pkg::ST_REPLY : kcf_pkg::ST_DUMP;
            end
            default: begin
              state_nxt = kcf_pkg::ST_REPLY;
            end
          endcase
        end
      end
      kcf_pkg::ST_POP: begin
        state_nxt = kcf_pkg::ST_REPLY;
      end
      kcf_pkg::ST_SEARCH: begin
        if (match_now) begin
          state_nxt = del_r ? kcf_pkg::ST_SHIFT : kcf_pkg::ST_REPLY;
        end else if (!more_rd && !rv_r) begin
          state_nxt = kcf_pkg::ST_REPLY;
        end
      end
      kcf_pkg::ST_SHIFT: begin
        if (!rv_r && !more_rd) begin
          state_nxt = kcf_pkg::ST_REPLY;
        end
      end
      kcf_pkg::ST_DUMP: begin
        if (dump_emit && dump_last) begin
          state_nxt = kcf_pkg::ST_IDLE;
        end
      end
      kcf_pkg::ST_REPLY: begin
        if (slot_free) begin
          state_nxt = kcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kcf_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, memory strobes and result
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    del_nxt        = del_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_off_nxt     = rd_off_r;
    cmp_addr_nxt   = cmp_addr_r;
    wr_addr_nxt    = wr_addr_r;
    rv_nxt         = rv_r;
    rep_status_nxt = rep_status_r;
    rep_key_nxt    = rep_key_r;
    rep_pay_nxt    = rep_pay_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr_r;
    mem_wkey       = rd_key_r;
    mem_wpay       = rd_pay_r;
    mem_re         = 1'b0;
    mem_raddr      = rd_ptr_r;
    emit           = 1'b0;
    emit_status    = rep_status_r;
    emit_key       = rep_key_r;
    emit_pay       = rep_pay_r;
    emit_last      = 1'b1;
    case (state_r)
      kcf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          key_nxt        = cmd.key;
          del_nxt        = (cmd.kind == kcf_pkg::CMD_DELETE);
          rep_status_nxt = 1'b1;
          rep_key_nxt    = '0;
          rep_pay_nxt    = '0;
          rd_ptr_nxt     = head_r;
          rd_off_nxt     = '0;
          rv_nxt         = 1'b0;
          case (cmd.kind)
            kcf_pkg::CMD_PUSH: begin
              if (count_r != DEPTH_CNT) begin
                tail_nxt       = wrap_inc(tail_r);
                mem_we         = 1'b1;
                mem_waddr      = wrap_inc(tail_r);
                mem_wkey       = cmd.key;
                mem_wpay       = SW'(cmd.payload);
                count_nxt      = count_r + 1'b1;
                rep_status_nxt = 1'b0;
              end
            end
            kcf_pkg::CMD_POP: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                head_nxt  = wrap_inc(head_r);
                count_nxt = count_r - 1'b1;
              end
            end
            kcf_pkg::CMD_CLEAR: begin
              head_nxt       = '0;
              tail_nxt       = LAST_IDX;
              count_nxt      = '0;
              rep_status_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      kcf_pkg::ST_POP: begin
        rep_status_nxt = 1'b0;
        rep_key_nxt    = rd_key_r;
        rep_pay_nxt    = rd_pay_r;
      end
      kcf_pkg::ST_SEARCH: begin
        if (match_now) begin
          rv_nxt         = 1'b0;
          wr_addr_nxt    = cmp_addr_r;
          rep_status_nxt = 1'b0;
          rep_key_nxt    = del_r ? '0 : rd_key_r;
          rep_pay_nxt    = del_r ? '0 : rd_pay_r;
        end else if (more_rd) begin
          mem_re       = 1'b1;
          cmp_addr_nxt = rd_ptr_r;
          rd_ptr_nxt   = wrap_inc(rd_ptr_r);
          rd_off_nxt   = rd_off_r + 1'b1;
          rv_nxt       = 1'b1;
        end else begin
          rv_nxt         = 1'b0;
          rep_status_nxt = 1'b1;
          rep_key_nxt    = '0;
          rep_pay_nxt    = '0;
        end
      end
      kcf_pkg::ST_SHIFT: begin
        // move each later record one slot toward the head
        if (rv_r) begin
          mem_we      = 1'b1;
          wr_addr_nxt = cmp_addr_r;
        end
        if (more_rd) begin
          mem_re       = 1'b1;
          cmp_addr_nxt = rd_ptr_r;
          rd_ptr_nxt   = wrap_inc(rd_ptr_r);
          rd_off_nxt   = rd_off_r + 1'b1;
          rv_nxt       = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (!rv_r && !more_rd) begin
          count_nxt = count_r - 1'b1;
          tail_nxt  = wrap_dec(tail_r);
        end
      end
      kcf_pkg::ST_DUMP: begin
        if (dump_emit) begin
          emit        = 1'b1;
          emit_status = 1'b0;
          emit_key    = rd_key_r;
          emit_pay    = rd_pay_r;
          emit_last   = dump_last;
          rv_nxt      = 1'b0;
        end
        if (more_dump && (!rv_r || dump_emit)) begin
          mem_re       = 1'b1;
          cmp_addr_nxt = rd_ptr_r;
          rd_ptr_nxt   = wrap_inc(rd_ptr_r);
          rd_off_nxt   = rd_off_r + 1'b1;
          rv_nxt       = 1'b1;
        end
      end
      kcf_pkg::ST_REPLY: begin
        emit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kcf_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= LAST_IDX;
      count_r      <= '0;
      del_r        <= 1'b0;
      rd_ptr_r     <= '0;
      rd_off_r     <= '0;
      cmp_addr_r   <= '0;
      wr_addr_r    <= '0;
      rv_r         <= 1'b0;
      rep_status_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      del_r        <= del_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      rd_off_r     <= rd_off_nxt;
      cmp_addr_r   <= cmp_addr_nxt;
      wr_addr_r    <= wr_addr_nxt;
      rv_r         <= rv_nxt;
      rep_status_r <= rep_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    rep_key_r <= rep_key_nxt;
    rep_pay_r <= rep_pay_nxt;
    if (emit) begin
      out_data_r.status         <= emit_status;
      out_data_r.record_key     <= emit_key;
      out_data_r.record_payload <= kcf_pkg::PAY_W'(emit_pay);
      out_data_r.fill_count     <= kcf_pkg::FILL_W'(count_r);
      out_data_r.is_full        <= (count_r == DEPTH_CNT);
      out_data_r.is_empty       <= (count_r == '0);
      out_data_r.last           <= emit_last;
    end
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      pay_mem[mem_waddr] <= mem_wpay;
    end
    if (mem_re) begin
      rd_key_r <= key_mem[mem_raddr];
      rd_pay_r <= pay_mem[mem_raddr];
    end
  end

endmodule

/* src/kcf_checker.sv */
// port-level checks of the keyed circular fifo, bound to the top level
// depends on kcf_pkg and assert_macros.svh
`include "assert_macros.svh"

module kcf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input kcf_pkg::in_t   in_data,
  input logic           out_valid,
  input logic           out_ready,
  input kcf_pkg::out_t  out_data
);

  logic fail_seen;
  logic rec_zero;
  logic empty_ok;
  logic out_stall;

  assign fail_seen = out_valid && out_data.status;
  assign rec_zero  = (out_data.record_key == 0) && (out_data.record_payload == 0);
  assign empty_ok  = (out_data.fill_count == '0) && !out_data.is_full;
  assign out_stall = out_valid && !out_ready;

  `KCF_ASSERT_RST(a_no_result_after_reset, clk, !rst_n |=> !out_valid)
  `KCF_ASSERT(a_fail_is_last, clk, rst_n, fail_seen |-> out_data.last)
  `KCF_ASSERT(a_fail_no_record, clk, rst_n, fail_seen |-> rec_zero)
  `KCF_ASSERT(a_empty_flags, clk, rst_n, out_valid && out_data.is_empty |-> empty_ok)
  `KCF_ASSERT(a_result_held, clk, rst_n, out_stall |=> out_valid && $stable(out_data))

endmodule

bind keyed_circular_fifo_core kcf_checker u_kcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/testbench.sv */
// self-checking testbench for keyed_circular_fifo_core: directed table, then random traffic
// depends on kcf_pkg and the core; a behavioral fifo model predicts results, except for typed directed rows
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = kcf_pkg::KCF_DEPTH;
  localparam int RANDOM_ITEMS = 350;
  localparam logic [kcf_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [kcf_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    kcf_pkg::in_t               item;
    int unsigned                reps;
    bit                         typed;
    logic                       want_status;
    logic [kcf_pkg::FILL_W-1:0] want_fill;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kcf_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kcf_pkg::out_t out_data;

  logic [kcf_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [kcf_pkg::PAY_W-1:0] pay_mem [DEPTH];
  int unsigned head_ptr = 0;
  int unsigned tail_ptr = DEPTH - 1;
  int unsigned held = 0;

  kcf_pkg::out_t step_results[$];
  kcf_pkg::out_t pending_results[$];
  stim_row_t directed[$];

  int idle_pct = 20;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int dumps_sent = 0;
  int full_hits = 0;

  keyed_circular_fifo_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic kcf_pkg::out_t fifo_result(logic st, logic [kcf_pkg::KEY_W-1:0] k,
                                                logic [kcf_pkg::PAY_W-1:0] p, logic fin);
    kcf_pkg::out_t r;
    r.status         = st;
    r.record_key     = k;
    r.record_payload = p;
    r.fill_count     = held[kcf_pkg::FILL_W-1:0];
    r.is_full        = (held == DEPTH);
    r.is_empty       = (held == 0);
    r.last           = fin;
    return r;
  endfunction

  function automatic int unsigned match_offset(logic [kcf_pkg::KEY_W-1:0] k);
    int unsigned s;
    s = 0;
    while (s < held && key_mem[(head_ptr + s) % DEPTH] != k) s++;
    return s;
  endfunction

  task automatic apply_fifo_op(input kcf_pkg::in_t item);
    int unsigned s, i, idx, nxt, n;
    step_results.delete();
    case (item.operation)
      kcf_pkg::OP_PUSH: begin
        if (held >= DEPTH) begin
          step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
        end else begin
          tail_ptr = (tail_ptr + 1) % DEPTH;
          key_mem[tail_ptr] = item.key;
          pay_mem[tail_ptr] = item.payload;
          held++;
          step_results.push_back(fifo_result(1'b0, '0, '0, 1'b1));
        end
      end
      kcf_pkg::OP_POP: begin
        if (held == 0) begin
          step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
        end else begin
          idx = head_ptr;
          head_ptr = (idx + 1) % DEPTH;
          held--;
          step_results.push_back(fifo_result(1'b0, key_mem[idx], pay_mem[idx], 1'b1));
        end
      end
      kcf_pkg::OP_FIND: begin
        s = match_offset(item.key);
        if (s >= held) begin
          step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
        end else begin
          idx = (head_ptr + s) % DEPTH;
          step_results.push_back(fifo_result(1'b0, key_mem[idx], pay_mem[idx], 1'b1));
        end
      end
      kcf_pkg::OP_DELETE: begin
        s = match_offset(item.key);
        if (s >= held) begin
          step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
        end else begin
          idx = (head_ptr + s) % DEPTH;
          for (i = s + 1; i < held; i++) begin
            nxt = (idx + 1) % DEPTH;
            key_mem[idx] = key_mem[nxt];
            pay_mem[idx] = pay_mem[nxt];
            idx = nxt;
          end
          held--;
          tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
          step_results.push_back(fifo_result(1'b0, '0, '0, 1'b1));
        end
      end
      kcf_pkg::OP_DUMP: begin
        if (held == 0) begin
          step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
        end else begin
          n = (held < kcf_pkg::MAX_RESULTS) ? held : kcf_pkg::MAX_RESULTS;
          for (i = 0; i < n; i++) begin
            idx = (head_ptr + i) % DEPTH;
            step_results.push_back(fifo_result(1'b0, key_mem[idx], pay_mem[idx], i + 1 == n));
          end
        end
      end
      kcf_pkg::OP_CLEAR: begin
        head_ptr = 0;
        tail_ptr = DEPTH - 1;
        held = 0;
        step_results.push_back(fifo_result(1'b0, '0, '0, 1'b1));
      end
      default: begin
        step_results.push_back(fifo_result(1'b1, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic add_row(input logic [kcf_pkg::OP_W-1:0] op,
                         input logic [kcf_pkg::KEY_W-1:0] k,
                         input logic [kcf_pkg::PAY_W-1:0] p, input int unsigned reps,
                         input bit typed, input logic st,
                         input logic [kcf_pkg::FILL_W-1:0] fill);
    stim_row_t row;
    row.item.operation = op;
    row.item.key       = k;
    row.item.payload   = p;
    row.reps           = reps;
    row.typed          = typed;
    row.want_status    = st;
    row.want_fill      = fill;
    directed.push_back(row);
  endtask

  task automatic send_op(input kcf_pkg::in_t item, input bit typed, input logic want_st,
                         input logic [kcf_pkg::FILL_W-1:0] want_fill);
    kcf_pkg::out_t r;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_fifo_op(item);
    if (typed) begin
      r.status         = want_st;
      r.record_key     = '0;
      r.record_payload = '0;
      r.fill_count     = want_fill;
      r.is_full        = (want_fill == DEPTH);
      r.is_empty       = (want_fill == 0);
      r.last           = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (step_results[j]) pending_results.push_back(step_results[j]);
    end
    items_sent++;
    if (item.operation == kcf_pkg::OP_DUMP) dumps_sent++;
    if (held == DEPTH) full_hits++;
  endtask

  function automatic kcf_pkg::in_t random_op(int unsigned target);
    kcf_pkg::in_t it;
    int unsigned r;
    it.key     = $urandom;
    it.payload = $urandom;
    r = $urandom_range(0, 99);
    if (r < ((held < target) ? 55 : 15)) begin
      it.operation = kcf_pkg::OP_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 22) it.operation = kcf_pkg::OP_POP;
      else if (r < 44) it.operation = kcf_pkg::OP_FIND;
      else if (r < 68) it.operation = kcf_pkg::OP_DELETE;
      else if (r < 84) it.operation = kcf_pkg::OP_DUMP;
      else if (r < 90) it.operation = kcf_pkg::OP_CLEAR;
      else if (r < 95) it.operation = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      else it.operation = kcf_pkg::OP_PUSH;
    end
    r = $urandom_range(0, 99);
    if (held != 0 && ((r < 75 && (it.operation == kcf_pkg::OP_FIND ||
                                  it.operation == kcf_pkg::OP_DELETE)) ||
                      (r < 20 && it.operation == kcf_pkg::OP_PUSH))) begin
      it.key = key_mem[(head_ptr + $urandom_range(0, held - 1)) % DEPTH];
    end else if (r >= 85) begin
      it.key = $urandom_range(0, 6) - 3;
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    kcf_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none, got %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("record_key", want.record_key, out_data.record_key);
        check_field("record_payload", want.record_payload, out_data.record_payload);
        check_field("fill_count", 32'(want.fill_count), 32'(out_data.fill_count));
        check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
        check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    kcf_pkg::in_t item;
    int unsigned target;
    target = DEPTH / 2;

    add_row(kcf_pkg::OP_POP,    32'h0,        32'h0,        1, 1, 1'b1, 5'd0);
    add_row(kcf_pkg::OP_FIND,   32'h0,        32'h0,        1, 1, 1'b1, 5'd0);
    add_row(kcf_pkg::OP_DELETE, 32'h0,        32'h0,        1, 1, 1'b1, 5'd0);
    add_row(kcf_pkg::OP_DUMP,   32'h0,        32'h0,        1, 1, 1'b1, 5'd0);
    add_row(OP_UNUSED_LO,       32'hffffffff, 32'hffffffff, 1, 1, 1'b1, 5'd0);
    add_row(OP_UNUSED_HI,       32'h0,        32'h0,        1, 1, 1'b1, 5'd0);
    add_row(kcf_pkg::OP_PUSH,   32'h80000000, 32'h0,        1, 1, 1'b0, 5'd1);
    add_row(kcf_pkg::OP_PUSH,   32'h7fffffff, 32'hffffffff, 1, 1, 1'b0, 5'd2);
    add_row(kcf_pkg::OP_FIND,   32'h7fffffff, 32'h0,        1, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_FIND,   32'd12345,    32'h0,        1, 1, 1'b1, 5'd2);
    add_row(kcf_pkg::OP_DELETE, 32'h80000000, 32'h0,        1, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_POP,    32'h0,        32'h0,        1, 0, 1'b0, 5'd0);
    // wraps the ring, head no longer at entry zero
    add_row(kcf_pkg::OP_PUSH,   32'd100,      32'ha5a5a5a5, 16, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_PUSH,   32'hffffffff, 32'h5a5a5a5a, 1, 1, 1'b1, 5'd16);
    add_row(kcf_pkg::OP_DUMP,   32'h0,        32'h0,        1, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_DELETE, 32'd107,      32'h0,        1, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_DELETE, 32'd115,      32'h0,        1, 0, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_DELETE, 32'd999,      32'h0,        1, 1, 1'b1, 5'd14);
    add_row(kcf_pkg::OP_CLEAR,  32'h0,        32'h0,        1, 1, 1'b0, 5'd0);
    add_row(kcf_pkg::OP_DUMP,   32'h0,        32'h0,        1, 1, 1'b1, 5'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      for (int unsigned k = 0; k < directed[r].reps; k++) begin
        item = directed[r].item;
        item.key = item.key + k;
        item.payload = item.payload + k;
        send_op(item, directed[r].typed, directed[r].want_status, directed[r].want_fill);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 45;
        endcase
        target = $urandom_range(0, DEPTH);
      end
      if (n >= RANDOM_ITEMS - 50) idle_pct = 0;
      send_op(random_op(target), 1'b0, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d operations (%0d dumps), checked %0d result transfers", items_sent,
             dumps_sent, results_seen);
    $display("fifo ran full after %0d operations, %0d mismatches", full_hits, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/kcf_pkg.sv
src/kcf_front.sv
src/kcf_cmd_queue.sv
src/kcf_back.sv
src/keyed_circular_fifo_core.sv
src/kcf_checker.sv
tb/testbench.sv
